// ===== sv/stopwatch_mmss_seven_segment_assert.svh =====
// assertion macros used by the stopwatch port checker
`ifndef STOPWATCH_MMSS_SEVEN_SEGMENT_ASSERT_SVH
`define STOPWATCH_MMSS_SEVEN_SEGMENT_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define SWMM_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("stopwatch assertion failed");

// next-cycle implication, disabled while reset is asserted
`define SWMM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("stopwatch assertion failed");

`endif

// ===== sv/swmm_pkg.sv =====
// shared types, constants and the digit glyph table of the stopwatch
package swmm_pkg;

  localparam int DIGIT_COUNT = 4;
  localparam int ScanW = $clog2(DIGIT_COUNT);

  localparam logic [15:0] COMPARE_RESET = 16'd31250;

  // display scan positions
  localparam logic [ScanW-1:0] SCAN_MIN_TENS  = ScanW'(0);
  localparam logic [ScanW-1:0] SCAN_MIN_UNITS = ScanW'(1);
  localparam logic [ScanW-1:0] SCAN_SEC_TENS  = ScanW'(2);

  // digit limits
  localparam logic [3:0] UNITS_MAX = 4'd9;
  localparam logic [2:0] TENS_MAX  = 3'd5;

  // one input item, start_press in bit 0
  typedef struct packed {
    logic scan_tick;
    logic timer_tick;
    logic lap_press;
    logic pause_press;
    logic start_press;
  } swmm_item_t;

  // state view handed from the counter to the display decoder
  typedef struct packed {
    logic [2:0]       min_tens;
    logic [3:0]       min_units;
    logic [2:0]       sec_tens;
    logic [3:0]       sec_units;
    logic [ScanW-1:0] scan_idx;
    logic             pause_ind;
    logic             lap_mode;
    logic             run_flag;
  } swmm_disp_t;

  // one result item, segments in the low bits
  typedef struct packed {
    logic       running;
    logic       lap_lamp;
    logic       pause_lamp;
    logic [3:0] digit_enable;
    logic [7:0] segments;
  } swmm_result_t;

  // segment pattern a..g of one decimal digit, blank otherwise
  function automatic logic [6:0] glyph(input logic [3:0] d);
    logic [6:0] g;
    case (d)
      4'd0:    g = 7'h3F;
      4'd1:    g = 7'h06;
      4'd2:    g = 7'h5B;
      4'd3:    g = 7'h4F;
      4'd4:    g = 7'h66;
      4'd5:    g = 7'h6D;
      4'd6:    g = 7'h7D;
      4'd7:    g = 7'h07;
      4'd8:    g = 7'h7F;
      4'd9:    g = 7'h6F;
      default: g = 7'h00;
    endcase
    return g;
  endfunction

endpackage

// ===== sv/swmm_counter.sv =====
// stopwatch state: buttons, divider, bcd time digits and scan index
module swmm_counter
  import swmm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        fire_i,
  input  swmm_item_t  item_i,
  input  logic [15:0] tick_compare_i,
  output swmm_disp_t  next_o
);

  swmm_disp_t  st_q, st_d;
  logic [15:0] div_q, div_d;
  logic        at_limit;
  logic        sec_step;

  assign at_limit = (st_q.min_tens == TENS_MAX) && (st_q.min_units == UNITS_MAX) &&
                    (st_q.sec_tens == TENS_MAX) && (st_q.sec_units == UNITS_MAX);

  // next state for the item held in the input register
  always_comb begin
    st_d     = st_q;
    div_d    = div_q;
    sec_step = 1'b0;

    // buttons, in order start, pause, lap
    if (item_i.start_press && !st_q.lap_mode) begin
      st_d.run_flag  = 1'b1;
      st_d.pause_ind = 1'b0;
    end
    if (item_i.pause_press) begin
      st_d.run_flag  = 1'b0;
      st_d.pause_ind = 1'b1;
    end
    if (item_i.lap_press) begin
      st_d.lap_mode = 1'b1;
    end

    // divider counts with the run state after the buttons
    if (item_i.timer_tick && st_d.run_flag) begin
      if (div_q == tick_compare_i) begin
        div_d    = '0;
        sec_step = !st_d.lap_mode && !at_limit;
      end else begin
        div_d = div_q + 16'd1;
      end
    end

    // bcd ripple of one second
    if (sec_step) begin
      if (st_q.sec_units != UNITS_MAX) begin
        st_d.sec_units = st_q.sec_units + 4'd1;
      end else begin
        st_d.sec_units = '0;
        if (st_q.sec_tens != TENS_MAX) begin
          st_d.sec_tens = st_q.sec_tens + 3'd1;
        end else begin
          st_d.sec_tens = '0;
          if (st_q.min_units != UNITS_MAX) begin
            st_d.min_units = st_q.min_units + 4'd1;
          end else begin
            st_d.min_units = '0;
            st_d.min_tens  = st_q.min_tens + 3'd1;
          end
        end
      end
    end

    // scan index wraps over the digit count
    if (item_i.scan_tick) begin
      st_d.scan_idx = st_q.scan_idx + ScanW'(1);
    end
  end

  // state registers update on each item transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= '0;
      div_q <= '0;
    end else if (fire_i) begin
      st_q  <= st_d;
      div_q <= div_d;
    end
  end

  assign next_o = st_d;

endmodule

// ===== sv/swmm_display.sv =====
// display decoder: scanned digit glyph, decimal point, digit enable, lamps
module swmm_display
  import swmm_pkg::*;
(
  input  swmm_disp_t   disp_i,
  output swmm_result_t result_o
);

  logic [3:0] digit;

  // pick the scanned digit
  always_comb begin
    case (disp_i.scan_idx)
      SCAN_MIN_TENS:  digit = {1'b0, disp_i.min_tens};
      SCAN_MIN_UNITS: digit = disp_i.min_units;
      SCAN_SEC_TENS:  digit = {1'b0, disp_i.sec_tens};
      default:        digit = disp_i.sec_units;
    endcase
  end

  // pattern, decimal point on minute units, active-low enable
  always_comb begin
    result_o.segments     = {disp_i.scan_idx == SCAN_MIN_UNITS, glyph(digit)};
    result_o.digit_enable = ~(4'(1) << disp_i.scan_idx);
    result_o.pause_lamp   = disp_i.pause_ind;
    result_o.lap_lamp     = disp_i.lap_mode;
    result_o.running      = disp_i.run_flag;
  end

endmodule

// ===== sv/stopwatch_mmss_seven_segment.sv =====
// Minutes:seconds stopwatch with a four-digit multiplexed seven-segment display.
// One item is taken every cycle while the output side keeps up: it is held in
// an input register, the state update and display decode run in one pass, and
// the result lands in an output register, from which it is taken when the
// output side is ready. Throughput is one item per cycle, set by the single
// state update stage, unless the output side stalls. The user writes tick_compare
// through cfg_we_i/cfg_wdata_i only while idle; the block does not enforce it.
module stopwatch_mmss_seven_segment
  import swmm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  // input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,  // start_press, pause_press, lap_press, timer_tick,
                                       // scan_tick, zero pad
  // result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o   // segments[7:0], digit_enable[11:8], pause_lamp,
                                       // lap_lamp, running, zero pad
);

  logic         in_valid_q;
  swmm_item_t   in_item_q;
  logic         out_valid_q;
  swmm_result_t out_data_q;
  logic [15:0]  cmp_q;
  logic         fire;
  swmm_disp_t   disp_next;
  swmm_result_t result;

  // compare register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmp_q <= COMPARE_RESET;
    end else if (cfg_we_i) begin
      cmp_q <= cfg_wdata_i;
    end
  end

  // handshake: an item moves on when the result register is empty or being taken
  assign fire            = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || fire;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_item_q <= swmm_item_t'(s_axis_tdata_i[4:0]);
    end
  end

  swmm_counter u_counter (
    .clk_i,
    .rst_ni,
    .fire_i         (fire),
    .item_i         (in_item_q),
    .tick_compare_i (cmp_q),
    .next_o         (disp_next)
  );

  swmm_display u_display (
    .disp_i   (disp_next),
    .result_o (result)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_data_q <= result;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_data_q};

endmodule

// ===== sv/swmm_checker.sv =====
// port-level checker for the stopwatch, bound to the top level
`include "stopwatch_mmss_seven_segment_assert.svh"

module swmm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [15:0] m_axis_tdata_o
);

  logic lap_seen_q;

  // remember a transfer that showed the lap lamp
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lap_seen_q <= 1'b0;
    end else if (m_axis_tvalid_o && m_axis_tready_i && m_axis_tdata_o[13]) begin
      lap_seen_q <= 1'b1;
    end
  end

  `SWMM_ASSERT_NOW(a_one_digit, clk_i, rst_ni, m_axis_tvalid_o, $countones(m_axis_tdata_o[11:8]) == 3)
  `SWMM_ASSERT_NOW(a_dp_min_units, clk_i, rst_ni, m_axis_tvalid_o, m_axis_tdata_o[7] == (m_axis_tdata_o[11:8] == 4'b1101))
  `SWMM_ASSERT_NOW(a_run_not_paused, clk_i, rst_ni, m_axis_tvalid_o, !(m_axis_tdata_o[14] && m_axis_tdata_o[12]))
  `SWMM_ASSERT_NOW(a_lap_sticky, clk_i, rst_ni, m_axis_tvalid_o && lap_seen_q, m_axis_tdata_o[13])
  `SWMM_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o))

endmodule

bind stopwatch_mmss_seven_segment swmm_checker u_swmm_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

// ===== dv/stopwatch_display_checker.sv =====
// checker for the stopwatch: predicts every display result and compares the result stream
module stopwatch_display_checker
  import swmm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [7:0]  s_tdata_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [15:0] m_tdata_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          checked_o,
  output logic [15:0] divider_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // glyphs a..g of the digits 0..9, digit 0 in the low bits
  localparam logic [69:0] GLYPH_ROM = {7'h6F, 7'h7F, 7'h07, 7'h7D, 7'h6D,
                                       7'h66, 7'h4F, 7'h5B, 7'h06, 7'h3F};

  // own copy of the stopwatch state and its compare register
  logic [15:0]      tick_cmp = COMPARE_RESET;
  logic [15:0]      div_cnt = '0;
  logic [2:0]       min_tens = '0;
  logic [3:0]       min_units = '0;
  logic [2:0]       sec_tens = '0;
  logic [3:0]       sec_units = '0;
  logic             counting = 1'b0;
  logic             lap_held = 1'b0;
  logic             pause_lit = 1'b0;
  logic [ScanW-1:0] scan_pos = '0;

  swmm_result_t display_q[$];
  swmm_result_t got;
  swmm_result_t want;
  int           fails = 0;
  int           checked = 0;

  function automatic logic [6:0] glyph_bits(input logic [3:0] d);
    return (d < 4'd10) ? GLYPH_ROM[d*7 +: 7] : 7'h00;
  endfunction

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
      fails++;
    end
  endtask

  // presses, then the timer tick, then the scan tick; returns the expected display result
  task automatic step_stopwatch(input swmm_item_t it, output swmm_result_t r);
    if (it.start_press && !lap_held) begin
      counting = 1'b1;
      pause_lit = 1'b0;
    end
    if (it.pause_press) begin
      counting = 1'b0;
      pause_lit = 1'b1;
    end
    if (it.lap_press) lap_held = 1'b1;

    if (it.timer_tick && counting) begin
      if (div_cnt == tick_cmp) begin
        div_cnt = '0;
        // one second, held at the 59:59 limit and frozen in lap mode
        if (!lap_held && !(min_tens == TENS_MAX && min_units == UNITS_MAX &&
                           sec_tens == TENS_MAX && sec_units == UNITS_MAX)) begin
          if (sec_units < UNITS_MAX) sec_units++;
          else begin
            sec_units = '0;
            if (sec_tens < TENS_MAX) sec_tens++;
            else begin
              sec_tens = '0;
              if (min_units < UNITS_MAX) min_units++;
              else begin
                min_units = '0;
                if (min_tens < TENS_MAX) min_tens++;
              end
            end
          end
        end
      end else begin
        div_cnt = div_cnt + 16'd1;
      end
    end

    if (it.scan_tick) scan_pos = ScanW'((int'(scan_pos) + 1) % DIGIT_COUNT);

    case (scan_pos)
      SCAN_MIN_TENS:  r.segments = {1'b0, glyph_bits({1'b0, min_tens})};
      SCAN_MIN_UNITS: r.segments = {1'b1, glyph_bits(min_units)};
      SCAN_SEC_TENS:  r.segments = {1'b0, glyph_bits({1'b0, sec_tens})};
      default:        r.segments = {1'b0, glyph_bits(sec_units)};
    endcase
    r.digit_enable = ~(4'b0001 << scan_pos);
    r.pause_lamp = pause_lit;
    r.lap_lamp = lap_held;
    r.running = counting;
  endtask

  // compare result transfers, follow register writes, predict input transfers
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      tick_cmp = COMPARE_RESET;
      div_cnt = '0;
      min_tens = '0;
      min_units = '0;
      sec_tens = '0;
      sec_units = '0;
      counting = 1'b0;
      lap_held = 1'b0;
      pause_lit = 1'b0;
      scan_pos = '0;
      display_q.delete();
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        got = swmm_result_t'(m_tdata_i[14:0]);
        if (display_q.size() == 0) begin
          $error("result transfer with no expected result waiting");
          fails++;
        end else begin
          want = display_q.pop_front();
          check_field("segments", want.segments, got.segments);
          check_field("digit_enable", want.digit_enable, got.digit_enable);
          check_field("pause_lamp", want.pause_lamp, got.pause_lamp);
          check_field("lap_lamp", want.lap_lamp, got.lap_lamp);
          check_field("running", want.running, got.running);
          checked++;
        end
      end
      if (cfg_we_i) tick_cmp = cfg_wdata_i;
      if (s_tvalid_i && s_tready_i) begin
        step_stopwatch(swmm_item_t'(s_tdata_i[4:0]), want);
        display_q.push_back(want);
      end
    end
    fail_count_o <= fails;
    pending_o <= display_q.size();
    checked_o <= checked;
    divider_o <= div_cnt;
  end

endmodule

// ===== dv/tb_stopwatch_mmss_seven_segment.sv =====
// testbench top for the stopwatch: stimulus, receiver stalls, watchdog and verdict
module tb_stopwatch_mmss_seven_segment
  import swmm_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RESET_CYCLES   = 12;
  localparam int SETTLE_CYCLES  = 4;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_ITEMS    = 80;
  localparam int LONG_RUN_ITEMS = 120;
  localparam int LAP_ITEMS      = 60;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_BURSTY} rx_mode_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [7:0]  s_data = '0;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [15:0] m_data;

  int          fail_count;
  int          pending;
  int          checked;
  logic [15:0] exp_divider;

  int          burst_left = 0;
  bit          steady = 1'b1;
  int          sent = 0;
  int          settings = 0;
  int          idle_cycles = 0;
  rx_mode_e    rx_mode = RX_OPEN;
  int          mode_left = 0;
  int          stall_left = 0;

  // clock, 10 ns period
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  stopwatch_mmss_seven_segment dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  stopwatch_display_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .s_tvalid_i   (s_valid),
    .s_tready_i   (s_ready),
    .s_tdata_i    (s_data),
    .m_tvalid_i   (m_valid),
    .m_tready_i   (m_ready),
    .m_tdata_i    (m_data),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked),
    .divider_o    (exp_divider)
  );

  // receiver stalls: open, coin flip, or rare longer stalls, switching at random
  always @(negedge clk_i) begin
    if (mode_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 2));
      mode_left = $urandom_range(64, 256);
    end
    mode_left--;
    case (rx_mode)
      RX_OPEN: m_ready <= 1'b1;
      RX_COIN: m_ready <= 1'($urandom_range(0, 1));
      default: begin
        if (stall_left == 0 && $urandom_range(0, 15) == 0) stall_left = $urandom_range(1, 10);
        if (stall_left > 0) begin
          stall_left--;
          m_ready <= 1'b0;
        end else begin
          m_ready <= 1'b1;
        end
      end
    endcase
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_valid && s_ready) || (m_valid && m_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WATCHDOG_LIMIT) begin
          $display("[stopwatch_mmss_seven_segment] ERROR");
          $finish;
        end
      end
    end
  end

  function automatic swmm_item_t press(input bit start, input bit pause, input bit lap,
                                       input bit tick, input bit scan);
    swmm_item_t it;
    it.start_press = start;
    it.pause_press = pause;
    it.lap_press = lap;
    it.timer_tick = tick;
    it.scan_tick = scan;
    return it;
  endfunction

  // one input transfer, in bursts with random gaps unless steady
  task automatic send_item(input swmm_item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if (!steady) begin
        gap = $urandom_range(0, 12);
        repeat (gap) begin
          @(negedge clk_i);
          s_valid <= 1'b0;
        end
      end
    end
    burst_left--;
    @(negedge clk_i);
    s_valid <= 1'b1;
    s_data <= {3'b000, it};
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
    sent++;
  endtask

  // hold the sender until every expected result is out
  task automatic wait_results_out();
    @(negedge clk_i);
    s_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_compare(input logic [15:0] value);
    wait_results_out();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    settings++;
  endtask

  initial begin
    swmm_item_t it;
    int roll;

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: idle item and every scan position at the reset compare
    send_item(press(0, 0, 0, 0, 0));
    repeat (4) send_item(press(0, 0, 0, 0, 1));

    // directed: compare of zero, presses combined in one item
    write_compare(16'd0);
    send_item(press(0, 1, 0, 0, 0));   // pause while stopped
    send_item(press(0, 0, 0, 1, 0));   // tick while stopped
    send_item(press(1, 0, 0, 1, 0));   // start and tick together
    send_item(press(1, 0, 0, 1, 1));   // start while running
    send_item(press(1, 1, 0, 1, 0));   // start then pause in one item
    send_item(press(1, 0, 0, 1, 1));
    send_item(press(0, 0, 0, 1, 1));
    send_item(press(0, 1, 0, 0, 1));

    // directed: largest compare, then a lowered one below the divider
    write_compare(16'hFFFF);
    send_item(press(1, 0, 0, 1, 0));
    send_item(press(0, 0, 0, 1, 1));
    send_item(press(0, 0, 0, 1, 0));
    send_item(press(1, 1, 0, 1, 1));
    write_compare(16'd2);
    send_item(press(1, 0, 0, 1, 0));
    send_item(press(0, 0, 0, 1, 0));
    send_item(press(0, 0, 0, 1, 0));
    send_item(press(0, 0, 0, 1, 1));

    // random phases without lap: mostly counting runs, some noise
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case ($urandom_range(0, 7))
        0:       write_compare(16'd0);
        1, 2, 3,
        4:       write_compare(16'($urandom_range(1, 12)));
        5:       write_compare(16'($urandom_range(13, 300)));
        6:       write_compare(16'($urandom));
        default: write_compare(16'hFFFF);
      endcase
      steady = (ph % 4 == 3);
      send_item(press(1, 0, 0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph % 4 == 1) begin
          it = swmm_item_t'(5'($urandom));
          it.lap_press = 1'b0;
        end else begin
          roll = $urandom_range(0, 99);
          it = press(roll < 4, roll >= 4 && roll < 8, 1'b0,
                     $urandom_range(0, 3) != 0, 1'($urandom_range(0, 1)));
        end
        send_item(it);
      end
    end

    // long run across minute carries: align divider, then one second per tick
    steady = 1'b0;
    wait_results_out();
    write_compare(exp_divider);
    send_item(press(1, 0, 0, 1, 0));
    write_compare(16'd0);
    repeat (LONG_RUN_ITEMS) send_item(press(0, 0, 0, 1, 1'($urandom_range(0, 1))));

    // lap mode: entered while running, start ignored afterwards, pause still works
    send_item(press(0, 0, 1, 1, 1));
    send_item(press(1, 0, 0, 1, 0));
    send_item(press(0, 1, 0, 0, 1));
    send_item(press(1, 0, 0, 1, 1));
    repeat (LAP_ITEMS) send_item(swmm_item_t'(5'($urandom)));

    wait_results_out();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("run covered %0d input transfers and %0d checked results over %0d settings,",
             sent, checked, settings);
    $display("including compare 0 and 65535, a lowered compare, minute carries and lap mode");
    if (fail_count == 0 && pending == 0) begin
      $display("[stopwatch_mmss_seven_segment] OK");
    end else begin
      $display("[stopwatch_mmss_seven_segment] ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/swmm_pkg.sv
sv/swmm_counter.sv
sv/swmm_display.sv
sv/stopwatch_mmss_seven_segment.sv
sv/swmm_checker.sv
dv/stopwatch_display_checker.sv
dv/tb_stopwatch_mmss_seven_segment.sv
